// ----- rtl/region_bump_allocator_macros.svh -----
// Assertion macros for the region bump allocator checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef REGION_BUMP_ALLOCATOR_MACROS_SVH
`define REGION_BUMP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RBA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rba: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define RBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rba: next-cycle check failed");

`endif

// ----- rtl/rba_pkg.sv -----
// Shared types and constants of the region bump allocator.
// No dependencies; used by the ALU, the top level and the checker.
`default_nettype none

package rba_pkg;

  // Default parameter values
  localparam int unsigned MAX_REGIONS_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF   = 52;

  // Fixed field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned ALIGN_W   = 5;
  localparam int unsigned QIDX_W    = 4;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CNT_OUT_W = 5;

  // Regions are clipped to start at 1 MiB
  localparam int unsigned  LOW_SHIFT = 20;
  localparam logic [63:0]  LOW_LIMIT = 64'h0000_0000_0010_0000;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR = 2'd0,
    FN_ADD   = 2'd1,
    FN_ALLOC = 2'd2,
    FN_QUERY = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_SKIPPED   = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Flags from the shared adder
  typedef struct packed {
    logic borrow;
    logic zero;
  } alu_flags_t;

endpackage

`default_nettype wire

// ----- rtl/rba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rba_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/rba_alu.sv -----
// Shared add/subtract unit of the region bump allocator.
// Depends on rba_pkg for the flag struct.
`default_nettype none

module rba_alu #(
  parameter int unsigned W = 54
) (
  input  wire logic [W-1:0]       a_i,
  input  wire logic [W-1:0]       b_i,
  input  wire logic               sub_i,
  output logic      [W-1:0]       sum_o,
  output rba_pkg::alu_flags_t     flags_o
);

  logic [W-1:0] b_x;
  logic [W:0]   full;

  // a + b, or a - b as a + ~b + 1
  assign b_x  = sub_i ? ~b_i : b_i;
  assign full = {1'b0, a_i} + {1'b0, b_x} + (W+1)'(sub_i);

  assign sum_o          = full[W-1:0];
  assign flags_o.borrow = sub_i & ~full[W];
  assign flags_o.zero   = (full[W-1:0] == '0);

endmodule

`default_nettype wire

// ----- rtl/region_bump_allocator.sv -----
// Top level of the region bump allocator: sequencer, region tables, result register.
// Depends on rba_pkg, rba_alu and rba_ram.
//
//  channel | dir | handshake               | beat content
//  --------+-----+-------------------------+---------------------------------------------
//  in      | in  | in_valid_i / in_stall_o  | func, entry fields, alloc size, align, index
//  out     | out | out_valid_o / out_stall_i| status, address, count, range base/length
//
// Steps from accepted beat to result: clear, skipped entry and zero size go to output;
// add entry forms the end, then the clipped length; allocate reads a region, then sums,
// aligns, takes offset, remainder and fit, then new offset and high-water, moving on to
// the next region on a miss; query reads and checks each entry until a match or the end.
// One shared adder does one step a cycle and the region tables have a single read port.
// Reset clears the cursor, counts and handshake state; the tables need no clearing pass.
// A result waits in the output register while the next beat is taken and worked on.
`default_nettype none

module region_bump_allocator #(
  parameter int unsigned MAX_REGIONS = rba_pkg::MAX_REGIONS_DEF,
  parameter int unsigned ADDR_BITS   = rba_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [rba_pkg::FUNC_W-1:0]      func_i,
  input  wire logic                            entry_usable_i,
  input  wire logic [ADDR_BITS-1:0]            entry_base_i,
  input  wire logic [ADDR_BITS-1:0]            entry_length_i,
  input  wire logic [ADDR_BITS-1:0]            alloc_size_i,
  input  wire logic [rba_pkg::ALIGN_W-1:0]     align_log2_i,
  input  wire logic [rba_pkg::QIDX_W-1:0]      query_index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [rba_pkg::STATUS_W-1:0]    status_o,
  output logic      [ADDR_BITS-1:0]            alloc_address_o,
  output logic      [rba_pkg::CNT_OUT_W-1:0]   reserved_count_o,
  output logic      [ADDR_BITS-1:0]            range_base_o,
  output logic      [ADDR_BITS-1:0]            range_length_o
);

  localparam int unsigned W         = ADDR_BITS + 2;
  localparam int unsigned HW_W      = ADDR_BITS + 1;
  localparam int unsigned CNT_W     = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IDX_W     = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned QIDX_W    = rba_pkg::QIDX_W;
  localparam int unsigned CMP_W     = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
  localparam int unsigned CNT_OUT_W = rba_pkg::CNT_OUT_W;
  localparam int unsigned LOW_SHIFT = rba_pkg::LOW_SHIFT;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);
  localparam logic [W-1:0]     LOW_W   = W'(rba_pkg::LOW_LIMIT);
  localparam logic [W-1:0]     SPAN_W  = {2'b01, {ADDR_BITS{1'b0}}};

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00_0000_0000_0001,
    S_E_END = 14'b00_0000_0000_0010,
    S_E_LEN = 14'b00_0000_0000_0100,
    S_A_RD  = 14'b00_0000_0000_1000,
    S_A_SUM = 14'b00_0000_0001_0000,
    S_A_ALN = 14'b00_0000_0010_0000,
    S_A_OFF = 14'b00_0000_0100_0000,
    S_A_REM = 14'b00_0000_1000_0000,
    S_A_FIT = 14'b00_0001_0000_0000,
    S_A_NEW = 14'b00_0010_0000_0000,
    S_A_HW  = 14'b00_0100_0000_0000,
    S_Q_RD  = 14'b00_1000_0000_0000,
    S_Q_CHK = 14'b01_0000_0000_0000,
    S_OUT   = 14'b10_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // architectural state
  logic [CNT_W-1:0] total_q, cur_q, resv_q;
  logic [HW_W-1:0]  cur_off_q;
  // walk state for a query
  logic [CNT_W-1:0] walk_q, seen_q;

  // captured beat and working registers
  logic [ADDR_BITS-1:0]         ebase_q, elen_q, asize_q;
  logic [rba_pkg::ALIGN_W-1:0]  lg_q;
  logic [QIDX_W-1:0]            qidx_q;
  logic [W-1:0]                 acc_q, off_q, aligned_q;
  rba_pkg::status_e             res_status_q;
  logic [ADDR_BITS-1:0]         res_addr_q, res_base_q, res_len_q;

  // output register
  logic                         out_valid_q;
  rba_pkg::status_e             out_status_q;
  logic [ADDR_BITS-1:0]         out_addr_q, out_base_q, out_len_q;
  logic [CNT_OUT_W-1:0]         out_count_q;

  logic in_accept, out_free;
  assign in_accept = in_valid_i & ~in_stall_o;
  assign out_free  = ~out_valid_q | ~out_stall_i;

  // region tables
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ADDR_BITS-1:0] rd_start, rd_size;
  logic [HW_W-1:0]      rd_hw;
  logic                 entry_wr, hw_wr;
  logic [IDX_W-1:0]     hw_addr;
  logic [HW_W-1:0]      hw_data;

  // shared adder
  logic [W-1:0]         alu_a, alu_b, alu_sum;
  logic                 alu_sub;
  rba_pkg::alu_flags_t  alu_flags;

  // entry clipping and alignment helpers
  logic                 end_over, base_low, hw_nz, q_hit;
  logic [W-1:0]         end_clip, base_clip, align_mask;

  assign end_over  = acc_q[ADDR_BITS+1] | (acc_q[ADDR_BITS] & (|acc_q[ADDR_BITS-1:0]));
  assign end_clip  = end_over ? SPAN_W : acc_q;
  assign base_low  = (ebase_q[ADDR_BITS-1:LOW_SHIFT] == '0);
  assign base_clip = base_low ? LOW_W : W'(ebase_q);
  assign align_mask = W'((64'd1 << lg_q) - 64'd1);
  assign hw_nz     = (rd_hw != '0);
  assign q_hit     = hw_nz && (CMP_W'(seen_q) == CMP_W'(qidx_q));

  // adder operand selection per step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_E_END: begin
        alu_a = W'(ebase_q);
        alu_b = W'(elen_q);
      end
      S_E_LEN: begin
        alu_a   = end_clip;
        alu_b   = base_clip;
        alu_sub = 1'b1;
      end
      S_A_SUM: begin
        alu_a = W'(rd_start);
        alu_b = W'(cur_off_q);
      end
      S_A_ALN: begin
        alu_a = acc_q;
        alu_b = align_mask;
      end
      S_A_OFF: begin
        alu_a   = acc_q;
        alu_b   = W'(rd_start);
        alu_sub = 1'b1;
      end
      S_A_REM: begin
        alu_a   = W'(rd_size);
        alu_b   = off_q;
        alu_sub = 1'b1;
      end
      S_A_FIT: begin
        alu_a   = acc_q;
        alu_b   = W'(asize_q);
        alu_sub = 1'b1;
      end
      S_A_NEW: begin
        alu_a = off_q;
        alu_b = W'(asize_q);
      end
      S_A_HW: begin
        alu_a   = W'(rd_hw);
        alu_b   = W'(cur_off_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  rba_alu #(
    .W (W)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .flags_o (alu_flags)
  );

  // table read and write controls
  assign rd_en    = ((state_q == S_A_RD) && (cur_q != total_q)) ||
                    ((state_q == S_Q_RD) && (walk_q != total_q));
  assign rd_addr  = (state_q == S_Q_RD) ? walk_q[IDX_W-1:0] : cur_q[IDX_W-1:0];
  assign entry_wr = (state_q == S_E_LEN) && !alu_flags.borrow && !alu_flags.zero &&
                    (total_q != MAX_CNT);
  assign hw_wr    = entry_wr || ((state_q == S_A_HW) && alu_flags.borrow);
  assign hw_addr  = entry_wr ? total_q[IDX_W-1:0] : cur_q[IDX_W-1:0];
  assign hw_data  = entry_wr ? '0 : cur_off_q;

  rba_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_REGIONS)
  ) u_start_ram (
    .clk_i     (clk_i),
    .wr_en_i   (entry_wr),
    .wr_addr_i (total_q[IDX_W-1:0]),
    .wr_data_i (base_clip[ADDR_BITS-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_start)
  );

  rba_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_REGIONS)
  ) u_size_ram (
    .clk_i     (clk_i),
    .wr_en_i   (entry_wr),
    .wr_addr_i (total_q[IDX_W-1:0]),
    .wr_data_i (alu_sum[ADDR_BITS-1:0]),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_size)
  );

  rba_ram #(
    .WIDTH (HW_W),
    .DEPTH (MAX_REGIONS)
  ) u_hw_ram (
    .clk_i     (clk_i),
    .wr_en_i   (hw_wr),
    .wr_addr_i (hw_addr),
    .wr_data_i (hw_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_hw)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (rba_pkg::func_e'(func_i))
            rba_pkg::FN_CLEAR: state_d = S_OUT;
            rba_pkg::FN_ADD:   state_d = entry_usable_i ? S_E_END : S_OUT;
            rba_pkg::FN_ALLOC: state_d = (alloc_size_i == '0) ? S_OUT : S_A_RD;
            default:           state_d = S_Q_RD;
          endcase
        end
      end
      S_E_END: state_d = S_E_LEN;
      S_E_LEN: state_d = S_OUT;
      S_A_RD:  state_d = (cur_q == total_q) ? S_OUT : S_A_SUM;
      S_A_SUM: state_d = S_A_ALN;
      S_A_ALN: state_d = S_A_OFF;
      S_A_OFF: state_d = S_A_REM;
      S_A_REM: state_d = alu_flags.borrow ? S_A_RD : S_A_FIT;
      S_A_FIT: state_d = alu_flags.borrow ? S_A_RD : S_A_NEW;
      S_A_NEW: state_d = S_A_HW;
      S_A_HW:  state_d = S_OUT;
      S_Q_RD:  state_d = (walk_q == total_q) ? S_OUT : S_Q_CHK;
      S_Q_CHK: state_d = q_hit ? S_OUT : S_Q_RD;
      S_OUT:   state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  // control state and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      cur_q       <= '0;
      cur_off_q   <= '0;
      resv_q      <= '0;
      walk_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            walk_q <= '0;
            seen_q <= '0;
            if (rba_pkg::func_e'(func_i) == rba_pkg::FN_CLEAR) begin
              total_q   <= '0;
              cur_q     <= '0;
              cur_off_q <= '0;
              resv_q    <= '0;
            end
          end
        end
        S_E_LEN: begin
          if (entry_wr) begin
            total_q <= total_q + CNT_W'(1);
          end
        end
        S_A_REM, S_A_FIT: begin
          // request does not fit: move on to the next region
          if (alu_flags.borrow) begin
            cur_q     <= cur_q + CNT_W'(1);
            cur_off_q <= '0;
          end
        end
        S_A_NEW: begin
          cur_off_q <= alu_sum[HW_W-1:0];
        end
        S_A_HW: begin
          if (!hw_nz) begin
            resv_q <= resv_q + CNT_W'(1);
          end
        end
        S_Q_CHK: begin
          walk_q <= walk_q + CNT_W'(1);
          if (hw_nz) begin
            seen_q <= seen_q + CNT_W'(1);
          end
        end
        default: begin
          walk_q <= walk_q;
        end
      endcase
    end
  end

  // captured beat, working values and result
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          ebase_q    <= entry_base_i;
          elen_q     <= entry_length_i;
          asize_q    <= alloc_size_i;
          lg_q       <= align_log2_i;
          qidx_q     <= query_index_i;
          res_addr_q <= '0;
          res_base_q <= '0;
          res_len_q  <= '0;
          case (rba_pkg::func_e'(func_i))
            rba_pkg::FN_ADD:
              res_status_q <= entry_usable_i ? rba_pkg::ST_OK : rba_pkg::ST_SKIPPED;
            rba_pkg::FN_ALLOC:
              res_status_q <= (alloc_size_i == '0) ? rba_pkg::ST_ZERO : rba_pkg::ST_OK;
            default:
              res_status_q <= rba_pkg::ST_OK;
          endcase
        end
      end
      S_E_END: acc_q <= alu_sum;
      S_E_LEN: begin
        if (alu_flags.borrow || alu_flags.zero) begin
          res_status_q <= rba_pkg::ST_SKIPPED;
        end else if (total_q == MAX_CNT) begin
          res_status_q <= rba_pkg::ST_FULL;
        end
      end
      S_A_RD: begin
        if (cur_q == total_q) begin
          res_status_q <= rba_pkg::ST_EXHAUSTED;
        end
      end
      S_A_SUM: acc_q <= alu_sum;
      S_A_ALN: begin
        acc_q     <= alu_sum & ~align_mask;
        aligned_q <= alu_sum & ~align_mask;
      end
      S_A_OFF: off_q <= alu_sum;
      S_A_REM: acc_q <= alu_sum;
      S_A_HW:  res_addr_q <= aligned_q[ADDR_BITS-1:0];
      S_Q_CHK: begin
        if (q_hit) begin
          res_base_q <= rd_start;
          res_len_q  <= rd_hw[ADDR_BITS-1:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_addr_q   <= res_addr_q;
          out_base_q   <= res_base_q;
          out_len_q    <= res_len_q;
          out_count_q  <= CNT_OUT_W'(resv_q);
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign alloc_address_o  = out_addr_q;
  assign reserved_count_o = out_count_q;
  assign range_base_o     = out_base_q;
  assign range_length_o   = out_len_q;

endmodule

`default_nettype wire

// ----- rtl/rba_checker.sv -----
// Port-level checks of the region bump allocator, bound to the top level.
// Depends on rba_pkg and region_bump_allocator_macros.svh.
`default_nettype none

`include "region_bump_allocator_macros.svh"

module rba_checker #(
  parameter int unsigned ADDR_BITS = rba_pkg::ADDR_BITS_DEF
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [rba_pkg::STATUS_W-1:0]   status_o,
  input wire logic [ADDR_BITS-1:0]           alloc_address_o,
  input wire logic [ADDR_BITS-1:0]           range_base_o,
  input wire logic [ADDR_BITS-1:0]           range_length_o
);

  localparam logic [ADDR_BITS-1:0] LOW_A = ADDR_BITS'(rba_pkg::LOW_LIMIT);

  // a taken beat raises the stall in the following cycle
  `RBA_ASSERT_NEXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o)

  // a stalled result beat holds
  `RBA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(alloc_address_o) && $stable(range_base_o))

  // an address only comes with a good allocation, never below 1 MiB
  `RBA_ASSERT_SAME(a_addr_ok, out_valid_o && alloc_address_o != '0, status_o == rba_pkg::ST_OK && alloc_address_o >= LOW_A)

  // a reported range lies in a clipped region
  `RBA_ASSERT_SAME(a_range_ok, out_valid_o && range_length_o != '0, status_o == rba_pkg::ST_OK && range_base_o >= LOW_A)

endmodule

bind region_bump_allocator rba_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_rba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .alloc_address_o (alloc_address_o),
  .range_base_o    (range_base_o),
  .range_length_o  (range_length_o)
);

`default_nettype wire
